// ===== src/i2c_master_register_access_defines.svh =====
// Assertion macros for the file that carries concurrent checks.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define I2CMRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cmra check failed");

// Next-cycle implication, checked outside reset.
`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cmra check failed");

`endif

// ===== src/i2cmra_pkg.sv =====
`default_nettype none

package i2cmra_pkg;

  // Command carried with each input transfer.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // Bus sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_SEND  = 3'd2,
    PH_ACKW  = 3'd3,
    PH_RECV  = 3'd4,
    PH_ACKR  = 3'd5,
    PH_STOP  = 3'd6
  } phase_t;

  // Which byte of the transaction the sequencer is on.
  typedef enum logic [1:0] {
    SG_DEV   = 2'd0,
    SG_REG   = 2'd1,
    SG_DATA  = 2'd2,
    SG_RADDR = 2'd3
  } stage_t;

  // Completion status codes.
  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_DEV_NACK    = 3'd1,
    STAT_REG_NACK    = 3'd2,
    STAT_DATA_NACK   = 3'd3,
    STAT_RADDR_NACK  = 3'd4
  } status_t;

  // One input item.
  typedef struct packed {
    cmd_t        cmd;
    logic [6:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [4:0]  byte_count;
    logic [7:0]  data_byte;
    logic        sda_in;
  } item_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic        done_res;
    logic [7:0]  rd_byte;
    logic        rd_valid;
    logic        busy_res;
    logic        sda_level;
    logic        scl;
  } res_t;

endpackage

`default_nettype wire

// ===== src/i2cmra_core.sv =====
`default_nettype none

module i2cmra_core #(
  parameter int MAX_BYTES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire i2cmra_pkg::item_t  item,
  output i2cmra_pkg::res_t        res
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CW = $clog2(MAX_BYTES + 1);

  // Sequencer state.
  i2cmra_pkg::phase_t phase_r, phase_nxt;
  i2cmra_pkg::stage_t stage_r, stage_nxt;
  i2cmra_pkg::status_t err_r, err_nxt;
  logic [1:0]    tick_r, tick_nxt;
  logic [3:0]    bit_r, bit_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [CW-1:0] load_idx_r, load_idx_nxt;
  logic [CW-1:0] byte_idx_r, byte_idx_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          rmode_r, rmode_nxt;
  logic [6:0]    dev_r, dev_nxt;
  logic [7:0]    reg_r, reg_nxt;
  logic          scl_r, scl_nxt;
  logic          sda_r, sda_nxt;

  // Write buffer with a registered read port.
  logic [7:0]    wbuf [MAX_BYTES];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          buf_we;

  // Combinational helpers.
  logic [2:0]          t;
  logic                go;
  i2cmra_pkg::phase_t  go_ph;
  logic                rd_valid;
  logic [7:0]          rd_byte;
  logic                done;
  i2cmra_pkg::status_t stat;

  // The next byte to send is fetched ahead: entry 0 before the data stage,
  // the entry after the current one during it.
  always_comb begin
    if (stage_r == i2cmra_pkg::SG_DATA) begin
      rd_addr = byte_idx_r[AW-1:0] + AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && buf_we) begin
      wbuf[load_idx_r[AW-1:0]] <= item.data_byte;
    end
    rd_data_r <= wbuf[rd_addr];
  end

  // Per-item step of the bus sequence.
  always_comb begin
    phase_nxt    = phase_r;
    stage_nxt    = stage_r;
    err_nxt      = err_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    load_idx_nxt = load_idx_r;
    byte_idx_nxt = byte_idx_r;
    total_nxt    = total_r;
    rmode_nxt    = rmode_r;
    dev_nxt      = dev_r;
    reg_nxt      = reg_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    buf_we       = 1'b0;
    go           = 1'b0;
    go_ph        = i2cmra_pkg::PH_IDLE;
    rd_valid     = 1'b0;
    rd_byte      = '0;
    done         = 1'b0;
    stat         = i2cmra_pkg::STAT_OK;
    t            = {1'b0, tick_r} + 3'd1;

    if (phase_r == i2cmra_pkg::PH_IDLE) begin
      if (item.cmd == i2cmra_pkg::CMD_LOAD) begin
        if (32'(load_idx_r) < MAX_BYTES) begin
          buf_we       = 1'b1;
          load_idx_nxt = load_idx_r + CW'(1);
        end
      end else if (item.cmd == i2cmra_pkg::CMD_WRITE || item.cmd == i2cmra_pkg::CMD_READ) begin
        dev_nxt = item.dev_addr;
        reg_nxt = item.reg_addr;
        if (32'(item.byte_count) > MAX_BYTES) begin
          total_nxt = CW'(MAX_BYTES);
        end else begin
          total_nxt = CW'(item.byte_count);
        end
        rmode_nxt    = (item.cmd == i2cmra_pkg::CMD_READ);
        byte_idx_nxt = '0;
        stage_nxt    = i2cmra_pkg::SG_DEV;
        err_nxt      = i2cmra_pkg::STAT_OK;
        go           = 1'b1;
        go_ph        = i2cmra_pkg::PH_START;
      end
    end else if (item.cmd == i2cmra_pkg::CMD_TICK) begin
      case (phase_r)
        i2cmra_pkg::PH_START: begin
          if (t == 3'd1) scl_nxt = 1'b1;
          else if (t == 3'd2) sda_nxt = 1'b0;
          else if (t == 3'd3) scl_nxt = 1'b0;
          if (t < 3'd4) begin
            tick_nxt = t[1:0];
          end else begin
            shift_nxt = {dev_r, stage_r == i2cmra_pkg::SG_RADDR};
            go        = 1'b1;
            go_ph     = i2cmra_pkg::PH_SEND;
          end
        end
        i2cmra_pkg::PH_SEND: begin
          if (t == 3'd1) begin
            scl_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else if (t == 3'd2) begin
            scl_nxt  = 1'b0;
            tick_nxt = t[1:0];
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            if (bit_nxt >= 4'd8) begin
              go    = 1'b1;
              go_ph = i2cmra_pkg::PH_ACKW;
            end else begin
              tick_nxt = '0;
              sda_nxt  = shift_nxt[7];
            end
          end
        end
        i2cmra_pkg::PH_ACKW: begin
          if (t == 3'd1) begin
            scl_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else if (item.sda_in) begin
            // No acknowledge: the status names the byte that was refused.
            case (stage_r)
              i2cmra_pkg::SG_DEV:  err_nxt = i2cmra_pkg::STAT_DEV_NACK;
              i2cmra_pkg::SG_REG:  err_nxt = i2cmra_pkg::STAT_REG_NACK;
              i2cmra_pkg::SG_DATA: err_nxt = i2cmra_pkg::STAT_DATA_NACK;
              default:             err_nxt = i2cmra_pkg::STAT_RADDR_NACK;
            endcase
            go    = 1'b1;
            go_ph = i2cmra_pkg::PH_STOP;
          end else begin
            scl_nxt = 1'b0;
            case (stage_r)
              i2cmra_pkg::SG_DEV: begin
                stage_nxt = i2cmra_pkg::SG_REG;
                shift_nxt = reg_r;
                go        = 1'b1;
                go_ph     = i2cmra_pkg::PH_SEND;
              end
              i2cmra_pkg::SG_REG: begin
                byte_idx_nxt = '0;
                go           = 1'b1;
                if (rmode_r) begin
                  stage_nxt = i2cmra_pkg::SG_RADDR;
                  go_ph     = i2cmra_pkg::PH_START;
                end else begin
                  stage_nxt = i2cmra_pkg::SG_DATA;
                  if (total_r == '0) begin
                    go_ph = i2cmra_pkg::PH_STOP;
                  end else begin
                    shift_nxt = rd_data_r;
                    go_ph     = i2cmra_pkg::PH_SEND;
                  end
                end
              end
              i2cmra_pkg::SG_DATA: begin
                byte_idx_nxt = byte_idx_r + CW'(1);
                go           = 1'b1;
                if (byte_idx_nxt >= total_r) begin
                  go_ph = i2cmra_pkg::PH_STOP;
                end else begin
                  shift_nxt = rd_data_r;
                  go_ph     = i2cmra_pkg::PH_SEND;
                end
              end
              default: begin
                byte_idx_nxt = '0;
                go           = 1'b1;
                if (total_r == '0) go_ph = i2cmra_pkg::PH_STOP;
                else go_ph = i2cmra_pkg::PH_RECV;
              end
            endcase
          end
        end
        i2cmra_pkg::PH_RECV: begin
          if (t == 3'd1) begin
            scl_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            bit_nxt   = bit_r + 4'd1;
            if (bit_nxt >= 4'd8) begin
              rd_valid = 1'b1;
              rd_byte  = shift_nxt;
              go       = 1'b1;
              go_ph    = i2cmra_pkg::PH_ACKR;
            end else begin
              tick_nxt = '0;
              scl_nxt  = 1'b0;
            end
          end
        end
        i2cmra_pkg::PH_ACKR: begin
          if (t == 3'd1) begin
            scl_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else if (t == 3'd2) begin
            scl_nxt  = 1'b0;
            tick_nxt = t[1:0];
          end else begin
            byte_idx_nxt = byte_idx_r + CW'(1);
            go           = 1'b1;
            if (byte_idx_nxt >= total_r) go_ph = i2cmra_pkg::PH_STOP;
            else go_ph = i2cmra_pkg::PH_RECV;
          end
        end
        default: begin
          // Stop condition: SCL up, then SDA up, then the transaction ends.
          if (t == 3'd1) begin
            scl_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else if (t == 3'd2) begin
            sda_nxt  = 1'b1;
            tick_nxt = t[1:0];
          end else begin
            phase_nxt    = i2cmra_pkg::PH_IDLE;
            tick_nxt     = '0;
            load_idx_nxt = '0;
            done         = 1'b1;
            stat         = err_r;
          end
        end
      endcase
    end

    // Entering a phase makes the line changes of its first step.
    if (go) begin
      phase_nxt = go_ph;
      tick_nxt  = '0;
      case (go_ph)
        i2cmra_pkg::PH_START: sda_nxt = 1'b1;
        i2cmra_pkg::PH_SEND: begin
          bit_nxt = '0;
          scl_nxt = 1'b0;
          sda_nxt = shift_nxt[7];
        end
        i2cmra_pkg::PH_ACKW: sda_nxt = 1'b1;
        i2cmra_pkg::PH_RECV: begin
          bit_nxt = '0;
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        i2cmra_pkg::PH_ACKR: begin
          scl_nxt = 1'b0;
          sda_nxt = ({1'b0, byte_idx_nxt} + (CW+1)'(1) < {1'b0, total_nxt}) ? 1'b0 : 1'b1;
        end
        i2cmra_pkg::PH_STOP: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Result of this item.
  always_comb begin
    res.scl       = scl_nxt;
    res.sda_level = sda_nxt;
    res.busy_res  = (phase_nxt != i2cmra_pkg::PH_IDLE);
    res.rd_valid  = rd_valid;
    res.rd_byte   = rd_byte;
    res.done_res  = done;
    res.status    = stat;
  end

  // State registers advance once per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= i2cmra_pkg::PH_IDLE;
      stage_r    <= i2cmra_pkg::SG_DEV;
      err_r      <= i2cmra_pkg::STAT_OK;
      tick_r     <= '0;
      bit_r      <= '0;
      shift_r    <= '0;
      load_idx_r <= '0;
      byte_idx_r <= '0;
      total_r    <= '0;
      rmode_r    <= 1'b0;
      dev_r      <= '0;
      reg_r      <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      stage_r    <= stage_nxt;
      err_r      <= err_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      load_idx_r <= load_idx_nxt;
      byte_idx_r <= byte_idx_nxt;
      total_r    <= total_nxt;
      rmode_r    <= rmode_nxt;
      dev_r      <= dev_nxt;
      reg_r      <= reg_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2c_master_register_access.sv =====
// Channel  | Direction | Transfer contents
// in_      | input     | one command: tick with sampled SDA, buffer load, or start
// out_     | output    | one result per command: line levels, read byte, status
//
// Each input transfer yields exactly one output transfer.
// Sustained rate is one item per clock while the output is not stalled; each item passes
// the input register, then the sequencer step into the output register.
// A stalled output holds its result while one more item waits in the input register.
// Synchronous active-low reset releases both bus lines and returns to idle.
// The write buffer has no reset; its read port is registered and fetched ahead.
`default_nettype none

`include "i2c_master_register_access_defines.svh"

module i2c_master_register_access #(
  parameter int MAX_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [6:0] dev_addr, [14:7] reg_addr, [19:15] byte_count, [27:20] data_byte,
  // [28] sda_in, [31:29] zero
  input  wire logic [31:0] in_tdata,
  // [1:0] cmd
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] scl, [1] sda_level, [2] busy_res, [3] rd_valid, [11:4] rd_byte,
  // [12] done_res, [15:13] status
  output logic [15:0]      out_tdata
);

  logic               in_valid_r;
  i2cmra_pkg::item_t  in_item_r;
  logic               out_valid_r;
  i2cmra_pkg::res_t   out_res_r;
  i2cmra_pkg::res_t   step_res;
  logic               advance;
  logic               in_fire;

  // The step runs when an item waits and the output register is free or being read out.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.cmd        <= i2cmra_pkg::cmd_t'(in_tuser);
      in_item_r.dev_addr   <= in_tdata[6:0];
      in_item_r.reg_addr   <= in_tdata[14:7];
      in_item_r.byte_count <= in_tdata[19:15];
      in_item_r.data_byte  <= in_tdata[27:20];
      in_item_r.sda_in     <= in_tdata[28];
    end
  end

  i2cmra_core #(
    .MAX_BYTES(MAX_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(advance),
    .item   (in_item_r),
    .res    (step_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.status, out_res_r.done_res, out_res_r.rd_byte,
                       out_res_r.rd_valid, out_res_r.busy_res, out_res_r.sda_level,
                       out_res_r.scl};

  // Checks on the pipeline and the result fields.
  `I2CMRA_ASSERT_NEXT(a_step_fills_out, clk, rst_n, advance, out_valid_r)
  `I2CMRA_ASSERT_NEXT(a_wait_holds_item, clk, rst_n, in_valid_r && !advance,
    in_valid_r && $stable(in_item_r))
  `I2CMRA_ASSERT_NOW(a_done_not_busy, clk, rst_n, out_valid_r && out_res_r.done_res,
    !out_res_r.busy_res)
  `I2CMRA_ASSERT_NOW(a_status_only_done, clk, rst_n, out_valid_r && !out_res_r.done_res,
    out_res_r.status == i2cmra_pkg::STAT_OK)

endmodule

`default_nettype wire
